/* rtl/bba_pkg.sv */
// Shared types, constants and helper functions for the bitmap block allocator.
`timescale 1ns / 1ps

package bba_pkg;

    // Bitmap storage geometry
    localparam int MAP_BYTES = 2048;
    localparam int ADDR_W    = $clog2(MAP_BYTES);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int POS_W     = ADDR_W + 3;
    localparam int SPAN_W    = POS_W + 1;

    // Field and register widths
    localparam int BASE_W  = 16;
    localparam int BYTES_W = 12;
    localparam int ITEM_W  = 17;
    localparam int LEN_W   = 15;
    localparam int CFG_W   = 16;

    // Request modes
    localparam logic [1:0] MODE_ALLOC_ONE = 2'd0;
    localparam logic [1:0] MODE_ALLOC_RUN = 2'd1;
    localparam logic [1:0] MODE_FREE_ONE  = 2'd2;
    localparam logic [1:0] MODE_FREE_RUN  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_CONFLICT = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // Configuration register indexes
    localparam logic CFG_BASE_OFFSET  = 1'b0;
    localparam logic CFG_BYTES_IN_USE = 1'b1;

    localparam logic [7:0] BYTE_ALL_SET = 8'hff;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ITEM_W-1:0] item_number;
        logic [LEN_W-1:0]  run_length;
    } req_t;

    typedef struct packed {
        logic [ITEM_W-1:0] granted_number;
        logic [1:0]        status;
    } rsp_t;

    // Index of the lowest clear bit of a byte (byte must not be all ones)
    function automatic logic [2:0] first_zero(input logic [7:0] b);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!b[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // Bits lo..hi of a byte set
    function automatic logic [7:0] bit_mask(input logic [2:0] lo, input logic [2:0] hi);
        return (BYTE_ALL_SET << lo) & (BYTE_ALL_SET >> (3'd7 - hi));
    endfunction

endpackage

/* rtl/bitmap_block_allocator.sv */
// Bitmap block allocator: byte-wide map memory with a scan and run-update sequencer.
`timescale 1ns / 1ps
//
//  channel  | signals                      | direction | accepted when
//  ---------+------------------------------+-----------+------------------------------
//  request  | req_valid, req_stall, req    | in        | req_valid high, req_stall low
//  result   | rsp_valid, rsp_stall, rsp    | out       | rsp_valid high, rsp_stall low
//  config   | cfg_we, cfg_index, cfg_data  | in        | cfg_we high
//
//  One item at a time. An allocation first runs the lowest-free scan over the map bytes; both
//  modes then pass over the R bytes of the run twice (a check pass, then a read-modify-write
//  pass), one read per cycle in each pass. Errors end early. The next item is taken once the
//  sequencer is back in its idle state.
//  After reset a clearing pass writes zero to all 2048 map bytes, one per cycle, with
//  req_stall high throughout. Config writes are taken at any time.
//  A finished result waits in the output register while the next item is accepted;
//  the sequencer holds in its done state only if that register is still full.

module bitmap_block_allocator (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  bba_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output bba_pkg::rsp_t             rsp,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [bba_pkg::CFG_W-1:0] cfg_data
);
    import bba_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;   // zero the map after reset
    localparam logic [3:0] S_IDLE  = 4'd1;   // wait for an item
    localparam logic [3:0] S_PREP  = 4'd2;   // decode, early range checks
    localparam logic [3:0] S_SCAN  = 4'd3;   // look for the lowest clear bit
    localparam logic [3:0] S_RANGE = 4'd4;   // check run against the span
    localparam logic [3:0] S_RCHK  = 4'd5;   // verify every run bit
    localparam logic [3:0] S_RWR   = 4'd6;   // read-modify-write the run
    localparam logic [3:0] S_DONE  = 4'd7;   // hand result to output register

    logic [3:0]        state_reg, state_next;
    req_t              req_reg, req_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ITEM_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0]  end_reg, end_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic [ADDR_W-1:0] last_reg, last_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [ADDR_W-1:0] rd_addr_q_reg, rd_addr_q_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [ITEM_W-1:0] res_grant_reg, res_grant_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;
    logic [BASE_W-1:0] base_reg;
    logic [BYTES_W-1:0] bytes_reg;

    // Map memory: one write port, one registered read port
    logic [7:0]        map_mem [MAP_BYTES];
    logic [7:0]        rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    // Derived values
    logic [CNT_W-1:0]  nbytes;
    logic [SPAN_W-1:0] span;
    logic [ADDR_W-1:0] first_byte;
    logic [ADDR_W-1:0] last_byte;
    logic              can_issue;
    logic              last_seen;
    logic [2:0]        lo_bit;
    logic [2:0]        hi_bit;
    logic [7:0]        run_bits;
    logic [7:0]        bad_bits;
    logic              is_alloc;
    logic              is_run;
    logic              found;
    logic              conflict;
    logic              rsp_free;
    logic [POS_W-1:0]  end_calc;

    assign nbytes = (bytes_reg > BYTES_W'(MAP_BYTES)) ? CNT_W'(MAP_BYTES) : CNT_W'(bytes_reg);
    assign span   = {nbytes, 3'b000};

    assign is_alloc = (req_reg.mode == MODE_ALLOC_ONE) || (req_reg.mode == MODE_ALLOC_RUN);
    assign is_run   = (req_reg.mode == MODE_ALLOC_RUN) || (req_reg.mode == MODE_FREE_RUN);

    assign first_byte = pos_reg[POS_W-1:3];
    assign last_byte  = end_reg[POS_W-1:3];
    assign can_issue  = (issue_reg <= {1'b0, last_reg});
    assign last_seen  = rd_vld_reg && (rd_addr_q_reg == last_reg);

    // Bits of the byte in hand that belong to the run
    assign lo_bit   = (rd_addr_q_reg == first_byte) ? pos_reg[2:0] : 3'd0;
    assign hi_bit   = (rd_addr_q_reg == last_byte) ? end_reg[2:0] : 3'd7;
    assign run_bits = bit_mask(lo_bit, hi_bit);
    assign bad_bits = is_alloc ? (rd_data_reg & run_bits) : (~rd_data_reg & run_bits);

    assign found    = rd_vld_reg && (rd_data_reg != BYTE_ALL_SET);
    assign conflict = rd_vld_reg && (bad_bits != 8'd0);
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // Last position of the run; wraps mod 2^POS_W, exact whenever the run is in range
    assign end_calc = pos_reg[POS_W-1:0] + POS_W'(len_reg) - POS_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        end_next        = end_reg;
        issue_next      = issue_reg;
        last_next       = last_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rd_en           = 1'b0;
        rd_addr         = issue_reg[ADDR_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = rd_addr_q_reg;
        wr_data         = is_alloc ? (rd_data_reg | run_bits) : (rd_data_reg & ~run_bits);

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en      = 1'b1;
                wr_addr    = issue_reg[ADDR_W-1:0];
                wr_data    = 8'd0;
                issue_next = issue_reg + CNT_W'(1);
                if (issue_reg == CNT_W'(MAP_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    if ((req.mode == MODE_ALLOC_RUN) || (req.mode == MODE_FREE_RUN))
                    begin
                        len_next = req.run_length;
                    end
                    else
                    begin
                        len_next = LEN_W'(1);
                    end
                    state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                res_grant_next = '0;
                if (is_run && (len_reg == '0))
                begin
                    res_status_next = ST_RANGE;
                    state_next      = S_DONE;
                end
                else if (is_alloc)
                begin
                    if (nbytes == '0)
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        issue_next = '0;
                        last_next  = ADDR_W'(nbytes - CNT_W'(1));
                        state_next = S_SCAN;
                    end
                end
                else if (req_reg.item_number < ITEM_W'(base_reg))
                begin
                    res_status_next = ST_RANGE;
                    state_next      = S_DONE;
                end
                else
                begin
                    pos_next   = req_reg.item_number - ITEM_W'(base_reg);
                    state_next = S_RANGE;
                end
            end

            S_SCAN:
            begin
                rd_en = can_issue && !found;
                if (rd_en)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (found)
                begin
                    pos_next   = ITEM_W'({rd_addr_q_reg, first_zero(rd_data_reg)});
                    state_next = S_RANGE;
                end
                else if (last_seen)
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
            end

            S_RANGE:
            begin
                if ((pos_reg >= ITEM_W'(span)) ||
                    (ITEM_W'(len_reg) > (ITEM_W'(span) - pos_reg)))
                begin
                    res_status_next = ST_RANGE;
                    state_next      = S_DONE;
                end
                else
                begin
                    end_next   = end_calc;
                    issue_next = CNT_W'(first_byte);
                    last_next  = end_calc[POS_W-1:3];
                    state_next = S_RCHK;
                end
            end

            S_RCHK:
            begin
                rd_en = can_issue && !conflict;
                if (rd_en)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (conflict)
                begin
                    res_status_next = ST_CONFLICT;
                    state_next      = S_DONE;
                end
                else if (last_seen)
                begin
                    issue_next = CNT_W'(first_byte);
                    state_next = S_RWR;
                end
            end

            S_RWR:
            begin
                rd_en = can_issue;
                if (rd_en)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                // write back the byte read last cycle while the next one is read
                wr_en = rd_vld_reg;
                if (last_seen)
                begin
                    res_status_next = ST_OK;
                    res_grant_next  = is_alloc ? ITEM_W'(pos_reg + ITEM_W'(base_reg)) : '0;
                    state_next      = S_DONE;
                end
            end

            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.granted_number = res_grant_reg;
                    rsp_next.status         = res_status_reg;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Read tracking for the registered memory read port
    assign rd_vld_next    = rd_en;
    assign rd_addr_q_next = rd_en ? rd_addr : rd_addr_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            issue_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            base_reg      <= '0;
            bytes_reg     <= BYTES_W'(MAP_BYTES);
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            rd_vld_reg    <= rd_vld_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BASE_OFFSET:  base_reg  <= cfg_data[BASE_W-1:0];
                    CFG_BYTES_IN_USE: bytes_reg <= cfg_data[BYTES_W-1:0];
                    default:          base_reg  <= base_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        len_reg        <= len_next;
        pos_reg        <= pos_next;
        end_reg        <= end_next;
        last_reg       <= last_next;
        rd_addr_q_reg  <= rd_addr_q_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        rsp_reg        <= rsp_next;
    end

    // Map memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Map is only written by the clearing pass or the run update
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == S_CLEAR) || (state_reg == S_RWR)))
        else $error("map written outside clear or run update");

    // Read and write never hit the same byte in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write collide on one map byte");

    // A failed result carries no granted number (nor does a successful free, though only failures are checked)
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.granted_number == '0))
        else $error("granted number set on an error result");

    // An accepted item closes the request side until it is finished
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("second item accepted while one is in work");

endmodule
